FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SZ_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("szpd assertion failed");

// Next-cycle implication, disabled during reset.
`define SZ_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("szpd assertion failed");

`endif

FILE: rtl/core/szpd_pkg.sv
package szpd_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int THR_W      = 16;
  localparam int THR_FRAC   = 12;
  localparam int INF_W      = 17;
  localparam int SKIP_W     = 8;
  localparam int POS_W      = 16;
  localparam int WINDOW_DEF = 10;

  localparam int IN_DATA_W  = SAMPLE_W + SKIP_W;
  localparam int OUT_DATA_W = 8;

  // wide arithmetic is done in 32-bit limbs on one shared multiplier
  localparam int LIMB_W = 32;
  localparam int ACC_W  = 4 * LIMB_W;
  localparam int MA_W   = 3 * LIMB_W;
  localparam int MB_W   = 2 * LIMB_W;
  localparam int LHS_SH = 2 * THR_FRAC;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [THR_W-1:0] THR_RESET = 16'd4096;
  localparam logic [INF_W-1:0] INF_RESET = 17'd32768;
  localparam logic [INF_W-1:0] INF_ONE   = 17'h10000;
  localparam logic [POS_W-1:0] POS_MAX   = 16'hFFFF;

  // register index, taken from cfg_paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_INFLUENCE = 1'b1;

endpackage

FILE: rtl/core/szpd_ram.sv
module szpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/smoothed_zscore_peak_detector.sv
// Smoothed z-score peak detector: one signed Q16.16 sample per request in, one boundary flag
// per request out, in order. The filtered history of WINDOW+1 samples sits in a circular
// RAM; a candidate sample (past warm-up and rising above the previous raw sample) walks the
// WINDOW older entries through the RAM read port, one per cycle, to build the sum and sum of
// squares, then runs the exact squared z-score test as a string of 32x32 limb products on a
// single shared multiplier. A candidate's time from accept to result is set by the RAM
// walk and the limb multiply sequence (no limb products run when the sample is not above
// the window mean); any other sample skips both the walk and the multiplies. The history needs
// no clearing pass after reset: per-entry valid bits make unwritten entries read as zero.
// threshold (Q4.12) sits at byte address 0 and influence (Q1.16) at 4 on the APB port.
`include "assert_macros.svh"

module smoothed_zscore_peak_detector #(
  parameter int WINDOW = szpd_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [szpd_pkg::IN_DATA_W-1:0]   in_tdata,    // sample[31:0], skip_len[39:32]
  input  logic                             in_tuser,    // start_of_read

  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [szpd_pkg::OUT_DATA_W-1:0]  out_tdata,   // boundary[0], zero fill above

  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [szpd_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [szpd_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [szpd_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  import szpd_pkg::*;

  localparam int AW  = $clog2(WINDOW + 1);
  localparam int CW  = $clog2(WINDOW);
  localparam int SW  = SAMPLE_W + $clog2(WINDOW) + 1;
  localparam int DW  = SW + 1;
  localparam int PW1 = POS_W + 1;
  localparam logic [PW1-1:0] WIN_EXT = PW1'(WINDOW);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_WALK   = 4'd1;
  localparam logic [3:0] ST_WDRAIN = 4'd2;
  localparam logic [3:0] ST_DIFF   = 4'd3;
  localparam logic [3:0] ST_SETUP  = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_MDRAIN = 4'd6;
  localparam logic [3:0] ST_CMP    = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;
  localparam logic [3:0] ST_HOLD   = 4'd9;

  // multiply jobs: W*Q, minus S^2, var*thr^2, d^2
  localparam logic [1:0] JOB_WQ  = 2'd0;
  localparam logic [1:0] JOB_SS  = 2'd1;
  localparam logic [1:0] JOB_RHS = 2'd2;
  localparam logic [1:0] JOB_DD  = 2'd3;

  logic [3:0]              state_r, state_nxt;
  logic [1:0]              job_r, job_nxt;
  logic [THR_W-1:0]        thr_r, thr_nxt;
  logic [INF_W-1:0]        inf_r, inf_nxt;
  logic [SAMPLE_W-1:0]     hist0_r, hist0_nxt;
  logic [SAMPLE_W-1:0]     prev_r, prev_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [SKIP_W-1:0]       skip_r, skip_nxt;
  logic [AW-1:0]           wp_r, wp_nxt;
  logic [WINDOW:0]         hvld_r, hvld_nxt;
  logic [AW-1:0]           rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    rv_r, rv_nxt;
  logic                    vld_r, vld_nxt;
  logic                    pv_r, pv_nxt;
  logic                    pwalk_r, pwalk_nxt;
  logic                    psub_r, psub_nxt;
  logic [1:0]              shift_r, shift_nxt;
  logic [2*LIMB_W-1:0]     prod_r, prod_nxt;
  logic signed [SAMPLE_W-1:0] pval_r, pval_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [SW-1:0]    s_r, s_nxt;
  logic signed [DW-1:0]    d_r, d_nxt;
  logic [SAMPLE_W-1:0]     y_r, y_nxt;
  logic [MA_W-1:0]         ma_r, ma_nxt;
  logic [MB_W-1:0]         mb_r, mb_nxt;
  logic [1:0]              i_r, i_nxt;
  logic                    j_r, j_nxt;
  logic [1:0]              ilast_r, ilast_nxt;
  logic                    jlast_r, jlast_nxt;
  logic                    msub_r, msub_nxt;
  logic [ACC_W-1:0]        rhs_r, rhs_nxt;
  logic                    flag_r, flag_nxt;
  logic signed [50:0]      blend_r, blend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_bnd_r, out_bnd_nxt;

  logic                    ram_we;
  logic [SAMPLE_W-1:0]     ram_rdata;
  logic [SAMPLE_W-1:0]     filt;

  logic [SAMPLE_W-1:0]     walk_val;
  logic [LIMB_W-1:0]       walk_mag;
  logic [LIMB_W-1:0]       mul_a, mul_b;
  logic [2*LIMB_W-1:0]     mul_p;
  logic [ACC_W-1:0]        addend;

  logic [SAMPLE_W-1:0]     y_in;
  logic [POS_W-1:0]        idx;
  logic [SKIP_W-1:0]       skip_eff;
  logic                    cand;
  logic signed [DW-1:0]    d_calc;
  logic                    d_pos;
  logic [SW-1:0]           s_mag;
  logic [DW-1:0]           d_mag;
  logic [2*THR_W-1:0]      thr_sq;
  logic [INF_W-1:0]        w_sat;
  logic signed [SAMPLE_W:0] blend_diff;
  logic                    deliver_ok;

  szpd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW + 1)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (filt),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_bnd_r);
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[2])
      REG_THRESHOLD: cfg_prdata = CFG_DW'(thr_r);
      REG_INFLUENCE: cfg_prdata = CFG_DW'(inf_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // request decode, warm-up test and rise test
  assign y_in     = in_tdata[SAMPLE_W-1:0];
  assign idx      = in_tuser ? '0 : pos_r;
  assign skip_eff = in_tuser ? in_tdata[SAMPLE_W +: SKIP_W] : skip_r;
  assign cand     = ({1'b0, idx} > (PW1'(skip_eff) + WIN_EXT)) &&
                    ($signed(y_in) > $signed(prev_r));

  // shared 32x32 multiplier: window squares during the walk, limb products afterwards
  assign walk_val = vld_r ? ram_rdata : '0;
  assign walk_mag = walk_val[SAMPLE_W-1] ? (~walk_val + 1'b1) : walk_val;
  assign mul_a    = rv_r ? walk_mag : ma_r[LIMB_W*i_r +: LIMB_W];
  assign mul_b    = rv_r ? walk_mag : mb_r[LIMB_W*j_r +: LIMB_W];
  assign mul_p    = mul_a * mul_b;

  always_comb begin
    case (shift_r)
      2'd0:    addend = ACC_W'(prod_r);
      2'd1:    addend = ACC_W'(prod_r) << LIMB_W;
      2'd2:    addend = ACC_W'(prod_r) << (2 * LIMB_W);
      default: addend = ACC_W'(prod_r) << (3 * LIMB_W);
    endcase
  end

  assign d_calc = DW'($signed(y_r)) * DW'(WINDOW) - DW'(s_r);
  assign d_pos  = !d_r[DW-1] && (d_r != '0);
  assign s_mag  = s_r[SW-1] ? SW'(-s_r) : SW'(s_r);
  assign d_mag  = d_r;
  assign thr_sq = thr_r * thr_r;

  // blend as h0 + floor(w * (y - h0) / 2^16)
  assign w_sat      = (inf_r > INF_ONE) ? INF_ONE : inf_r;
  assign blend_diff = (SAMPLE_W + 1)'($signed(y_r)) - (SAMPLE_W + 1)'($signed(hist0_r));
  assign filt       = flag_r ? (hist0_r + blend_r[16 +: SAMPLE_W]) : y_r;

  assign deliver_ok = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    thr_nxt       = thr_r;
    inf_nxt       = inf_r;
    hist0_nxt     = hist0_r;
    prev_nxt      = prev_r;
    pos_nxt       = pos_r;
    skip_nxt      = skip_r;
    wp_nxt        = wp_r;
    hvld_nxt      = hvld_r;
    rd_addr_nxt   = rd_addr_r;
    cnt_nxt       = cnt_r;
    rv_nxt        = 1'b0;
    vld_nxt       = vld_r;
    pv_nxt        = 1'b0;
    pwalk_nxt     = pwalk_r;
    psub_nxt      = psub_r;
    shift_nxt     = shift_r;
    prod_nxt      = prod_r;
    pval_nxt      = pval_r;
    acc_nxt       = acc_r;
    s_nxt         = s_r;
    d_nxt         = d_r;
    y_nxt         = y_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ilast_nxt     = ilast_r;
    jlast_nxt     = jlast_r;
    msub_nxt      = msub_r;
    rhs_nxt       = rhs_r;
    flag_nxt      = flag_r;
    blend_nxt     = blend_r;
    out_valid_nxt = out_valid_r;
    out_bnd_nxt   = out_bnd_r;
    ram_we        = 1'b0;

    if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_THRESHOLD: thr_nxt = cfg_pwdata[THR_W-1:0];
        REG_INFLUENCE: inf_nxt = cfg_pwdata[INF_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // walk read data -> square
    if (rv_r) begin
      pv_nxt    = 1'b1;
      pwalk_nxt = 1'b1;
      psub_nxt  = 1'b0;
      shift_nxt = 2'd0;
      prod_nxt  = mul_p;
      pval_nxt  = $signed(walk_val);
    end

    // accumulate
    if (pv_r) begin
      acc_nxt = psub_r ? (acc_r - addend) : (acc_r + addend);
      if (pwalk_r) begin
        s_nxt = s_r + SW'(pval_r);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          skip_nxt = skip_eff;
          pos_nxt  = (idx == POS_MAX) ? POS_MAX : idx + 1'b1;
          prev_nxt = y_in;
          y_nxt    = y_in;
          flag_nxt = 1'b0;
          if (cand) begin
            acc_nxt     = '0;
            s_nxt       = '0;
            rd_addr_nxt = wp_r;
            cnt_nxt     = '0;
            state_nxt   = ST_WALK;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      // window = every slot but the newest, starting at the write pointer
      ST_WALK: begin
        rv_nxt      = 1'b1;
        vld_nxt     = hvld_r[rd_addr_r];
        rd_addr_nxt = (rd_addr_r == AW'(WINDOW)) ? '0 : rd_addr_r + 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CW'(WINDOW - 1)) begin
          state_nxt = ST_WDRAIN;
        end
      end
      ST_WDRAIN: begin
        if (!rv_r) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        d_nxt     = d_calc;
        job_nxt   = JOB_WQ;
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        i_nxt     = 2'd0;
        j_nxt     = 1'b0;
        state_nxt = ST_MUL;
        case (job_r)
          JOB_WQ: begin
            if (!d_pos) begin
              flag_nxt  = 1'b0;
              state_nxt = ST_FIN;
            end else begin
              ma_nxt    = acc_r[MA_W-1:0];
              mb_nxt    = MB_W'(WINDOW);
              ilast_nxt = 2'd2;
              jlast_nxt = 1'b0;
              msub_nxt  = 1'b0;
              acc_nxt   = '0;
            end
          end
          JOB_SS: begin
            ma_nxt    = MA_W'(s_mag);
            mb_nxt    = MB_W'(s_mag);
            ilast_nxt = 2'd1;
            jlast_nxt = 1'b1;
            msub_nxt  = 1'b1;
          end
          JOB_RHS: begin
            ma_nxt    = acc_r[MA_W-1:0];
            mb_nxt    = MB_W'(thr_sq);
            ilast_nxt = 2'd2;
            jlast_nxt = 1'b0;
            msub_nxt  = 1'b0;
            acc_nxt   = '0;
          end
          default: begin
            rhs_nxt   = acc_r;
            ma_nxt    = MA_W'(d_mag);
            mb_nxt    = MB_W'(d_mag);
            ilast_nxt = 2'd1;
            jlast_nxt = 1'b1;
            msub_nxt  = 1'b0;
            acc_nxt   = '0;
          end
        endcase
      end
      ST_MUL: begin
        pv_nxt    = 1'b1;
        pwalk_nxt = 1'b0;
        psub_nxt  = msub_r;
        shift_nxt = i_r + 2'(j_r);
        prod_nxt  = mul_p;
        if (j_r == jlast_r) begin
          j_nxt = 1'b0;
          if (i_r == ilast_r) begin
            state_nxt = ST_MDRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = 1'b1;
        end
      end
      ST_MDRAIN: begin
        if (job_r == JOB_DD) begin
          state_nxt = ST_CMP;
        end else begin
          job_nxt   = job_r + 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_CMP: begin
        flag_nxt  = (acc_r << LHS_SH) > rhs_r;
        blend_nxt = $signed({1'b0, w_sat}) * blend_diff;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        ram_we         = 1'b1;
        hvld_nxt[wp_r] = 1'b1;
        hist0_nxt      = filt;
        wp_nxt         = (wp_r == AW'(WINDOW)) ? '0 : wp_r + 1'b1;
        if (deliver_ok) begin
          out_valid_nxt = 1'b1;
          out_bnd_nxt   = flag_r;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (deliver_ok) begin
          out_valid_nxt = 1'b1;
          out_bnd_nxt   = flag_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THR_RESET;
      inf_r       <= INF_RESET;
      hist0_r     <= '0;
      prev_r      <= '0;
      pos_r       <= '0;
      skip_r      <= '0;
      wp_r        <= '0;
      hvld_r      <= '0;
      rv_r        <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      inf_r       <= inf_nxt;
      hist0_r     <= hist0_nxt;
      prev_r      <= prev_nxt;
      pos_r       <= pos_nxt;
      skip_r      <= skip_nxt;
      wp_r        <= wp_nxt;
      hvld_r      <= hvld_nxt;
      rv_r        <= rv_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    rd_addr_r <= rd_addr_nxt;
    cnt_r     <= cnt_nxt;
    vld_r     <= vld_nxt;
    pwalk_r   <= pwalk_nxt;
    psub_r    <= psub_nxt;
    shift_r   <= shift_nxt;
    prod_r    <= prod_nxt;
    pval_r    <= pval_nxt;
    acc_r     <= acc_nxt;
    s_r       <= s_nxt;
    d_r       <= d_nxt;
    y_r       <= y_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    ilast_r   <= ilast_nxt;
    jlast_r   <= jlast_nxt;
    msub_r    <= msub_nxt;
    rhs_r     <= rhs_nxt;
    flag_r    <= flag_nxt;
    blend_r   <= blend_nxt;
    out_bnd_r <= out_bnd_nxt;
  end

  // a job only starts once the last limb product has landed in the accumulator
  `SZ_ASSERT_IMP(a_setup_drained, clk, rst_n, state_r == ST_SETUP, !pv_r)
  // W*Q - S^2 can never go negative
  `SZ_ASSERT_IMP(a_var_nonneg, clk, rst_n, state_r == ST_SETUP && job_r == JOB_RHS,
                 !acc_r[ACC_W-1])
  // the window sum is complete before d is formed
  `SZ_ASSERT_NXT(a_walk_drained, clk, rst_n, state_r == ST_WDRAIN && !rv_r, !pv_r)
  // a flag is only raised for a sample above the window mean
  `SZ_ASSERT_IMP(a_flag_above_mean, clk, rst_n, state_r == ST_FIN && flag_r, d_pos)

endmodule
